>>> src/lprd_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed record deframer package
// Shared types, codes and constants for the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lprd_pkg;

  localparam int unsigned LengthBits     = 32;
  localparam int unsigned MaxPrefixBytes = 12;
  localparam int unsigned WideBits       = LengthBits + 8;

  typedef enum logic [0:0] {
    OP_DATA = 1'b0,
    OP_END  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    KIND_PREFIX  = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_EMPTY   = 3'd2,
    KIND_ERROR   = 3'd3,
    KIND_END     = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_OVERLONG = 3'd1,
    ERR_TOO_BIG  = 3'd2,
    ERR_END_PFX  = 3'd3,
    ERR_END_PLD  = 3'd4
  } err_e;

  typedef enum logic [3:0] {
    FMT_U8      = 4'd0,
    FMT_U16_LE  = 4'd1,
    FMT_U24_LE  = 4'd2,
    FMT_U32_LE  = 4'd3,
    FMT_U16_BE  = 4'd4,
    FMT_U24_BE  = 4'd5,
    FMT_U32_BE  = 4'd6,
    FMT_VAR_LO  = 4'd7,
    FMT_VAR_HI  = 4'd8
  } fmt_e;

  typedef enum logic [1:0] {
    PH_PREFIX  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } phase_e;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic       record_last;
    logic [2:0] error_code;
  } out_t;

  typedef struct packed {
    phase_e                phase;
    logic [3:0]            prefix_count;
    logic [LengthBits-1:0] length_accum;
    logic [LengthBits-1:0] payload_remaining;
    logic [2:0]            held_error;
  } state_t;

endpackage

`default_nettype wire

>>> src/length_prefixed_record_deframer.sv
// ----------------------------------------------------------------------------
// Length-prefixed record deframer
// Splits a byte stream into records behind length prefixes of nine formats.
// ----------------------------------------------------------------------------
// The deframer takes one word per cycle while the output is not stalled and
// returns exactly one result word for each input word. Each word passes an
// input register, one step of prefix and payload logic, and a result register,
// so throughput is one byte per clock while the output is not stalled. A write
// to the prefix format register takes effect for the byte held in the input
// register, even one already waiting there. After any error the block answers
// every word with the held error until reset.
`default_nettype none

module length_prefixed_record_deframer
  import lprd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o
);

  logic [3:0] fmt_val_q;
  logic       in_valid_q;
  in_t        in_item_q;
  logic       out_valid_q;
  out_t       out_item_q;
  state_t     state_q;
  state_t     state_d;
  out_t       result;
  logic       advance;

  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  lprd_step u_step (
    .state_i  (state_q),
    .fmt_i    (fmt_val_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_val_q   <= FMT_U8;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: PH_PREFIX, prefix_count: 4'd0, length_accum: '0,
                       payload_remaining: '0, held_error: ERR_NONE};
    end else begin
      if (cfg_we_i) begin
        fmt_val_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_data_i;
    end
    if (advance && in_valid_q) begin
      out_item_q <= result;
    end
  end

endmodule

`default_nettype wire

>>> src/lprd_step.sv
// ----------------------------------------------------------------------------
// Deframer step logic
// Computes the result word and the next parser state for one input word.
// ----------------------------------------------------------------------------
`default_nettype none

module lprd_step
  import lprd_pkg::*;
(
  input  state_t     state_i,
  input  logic [3:0] fmt_i,
  input  in_t        item_i,
  output state_t     state_o,
  output out_t       result_o
);

  logic [3:0]          fmt;
  logic [7:0]          b;
  logic [6:0]          grp;
  logic [3:0]          cnt;
  logic [3:0]          cnt_inc;
  logic [4:0]          need;
  logic [WideBits-1:0] acc_w;
  logic [WideBits-1:0] val;
  logic                grp_too_far;
  logic                done;
  logic                is_var;
  logic [LengthBits-1:0] remain_dec;

  always_comb begin
    fmt         = (fmt_i > FMT_VAR_HI) ? FMT_U8 : fmt_i;
    b           = item_i.data_byte;
    grp         = b[6:0];
    cnt         = state_i.prefix_count;
    cnt_inc     = (cnt == 4'hf) ? cnt : cnt + 4'd1;
    acc_w       = {8'd0, state_i.length_accum};
    grp_too_far = 1'b0;
    is_var      = (fmt == FMT_VAR_LO) || (fmt == FMT_VAR_HI);
    need        = 5'd1;
    val         = acc_w;
    done        = 1'b0;
    remain_dec  = state_i.payload_remaining - LengthBits'(1);

    case (fmt)
      FMT_VAR_LO: begin
        if (grp != 7'd0) begin
          case (cnt)
            4'd0: val = acc_w | WideBits'(grp);
            4'd1: val = acc_w | (WideBits'(grp) << 7);
            4'd2: val = acc_w | (WideBits'(grp) << 14);
            4'd3: val = acc_w | (WideBits'(grp) << 21);
            4'd4: val = acc_w | (WideBits'(grp) << 28);
            default: grp_too_far = 1'b1;
          endcase
        end
        done = ~b[7];
      end
      FMT_VAR_HI: begin
        val  = {1'b0, state_i.length_accum, grp};
        done = ~b[7];
      end
      FMT_U16_LE, FMT_U24_LE, FMT_U32_LE: begin
        case (cnt)
          4'd0: val = acc_w | WideBits'(b);
          4'd1: val = acc_w | (WideBits'(b) << 8);
          4'd2: val = acc_w | (WideBits'(b) << 16);
          4'd3: val = acc_w | (WideBits'(b) << 24);
          default: val = acc_w;
        endcase
        need = {1'b0, fmt} + 5'd1;
        done = ({1'b0, cnt} + 5'd1) >= need;
      end
      FMT_U16_BE, FMT_U24_BE, FMT_U32_BE: begin
        val  = {state_i.length_accum, b};
        need = {1'b0, fmt} - 5'd2;
        done = ({1'b0, cnt} + 5'd1) >= need;
      end
      default: begin
        val  = {state_i.length_accum, b};
        need = 5'd1;
        done = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_o  = state_i;
    result_o = '{kind: KIND_PREFIX, payload_byte: 8'd0, record_last: 1'b0,
                 error_code: ERR_NONE};

    if (state_i.phase != PH_PREFIX && state_i.phase != PH_PAYLOAD) begin
      state_o.phase       = PH_ERROR;
      result_o.kind       = KIND_ERROR;
      result_o.error_code = state_i.held_error;
    end else if (item_i.op == OP_END) begin
      if (state_i.phase == PH_PAYLOAD || cnt != 4'd0) begin
        state_o.phase       = PH_ERROR;
        state_o.held_error  = (state_i.phase == PH_PAYLOAD) ? ERR_END_PLD : ERR_END_PFX;
        result_o.kind       = KIND_ERROR;
        result_o.error_code = state_o.held_error;
      end else begin
        result_o.kind = KIND_END;
      end
    end else if (state_i.phase == PH_PAYLOAD) begin
      state_o.payload_remaining = remain_dec;
      result_o.kind             = KIND_PAYLOAD;
      result_o.payload_byte     = b;
      if (remain_dec == '0) begin
        state_o.phase        = PH_PREFIX;
        state_o.prefix_count = 4'd0;
        state_o.length_accum = '0;
        result_o.record_last = 1'b1;
      end
    end else if (grp_too_far || (val[WideBits-1:LengthBits] != '0)) begin
      state_o.phase       = PH_ERROR;
      state_o.held_error  = ERR_TOO_BIG;
      result_o.kind       = KIND_ERROR;
      result_o.error_code = ERR_TOO_BIG;
    end else begin
      state_o.length_accum = val[LengthBits-1:0];
      state_o.prefix_count = cnt_inc;
      if (!done) begin
        if (is_var && (cnt_inc >= 4'(MaxPrefixBytes))) begin
          state_o.phase       = PH_ERROR;
          state_o.held_error  = ERR_OVERLONG;
          result_o.kind       = KIND_ERROR;
          result_o.error_code = ERR_OVERLONG;
        end
      end else begin
        state_o.prefix_count = 4'd0;
        if (val[LengthBits-1:0] == '0) begin
          result_o.kind        = KIND_EMPTY;
          result_o.record_last = 1'b1;
        end else begin
          state_o.payload_remaining = val[LengthBits-1:0];
          state_o.length_accum      = '0;
          state_o.phase             = PH_PAYLOAD;
        end
      end
    end
  end

endmodule

`default_nettype wire
